// ===== hdl/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants for the sync/ID/length frame parser.
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam logic [7:0] SYNC_BYTE0 = 8'h23;
    localparam logic [7:0] SYNC_BYTE1 = 8'h3E;
    localparam logic [7:0] ID_BYTE0   = 8'h06;
    localparam logic [7:0] ID_BYTE1   = 8'h25;

    localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd8;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_PAYLOAD_LENGTH = 1'b0
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_ID   = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_OK       = 3'd1,
        ST_BAD_SYNC = 3'd2,
        ST_BAD_ID   = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_BAD_SUM  = 3'd5
    } status_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        status_t    frame_status;
    } result_t;

endpackage

// ===== hdl/bfp_cfg.sv =====
// ----------------------------------------------------------------------------
// bfp_cfg
// APB register file holding the expected payload length.
// ----------------------------------------------------------------------------
module bfp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bfp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bfp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [7:0]                       payload_length
);
    import bfp_pkg::*;

    logic [7:0] payload_length_reg;
    reg_index_t reg_index;
    logic       addr_hit;
    logic       wr_en;

    assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1]);
    assign addr_hit  = (reg_index == REG_PAYLOAD_LENGTH);
    assign wr_en     = psel && penable && pwrite && addr_hit;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_length_reg <= PAYLOAD_LENGTH_RESET;
        end else if (wr_en) begin
            payload_length_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (addr_hit) begin
            prdata[7:0] = payload_length_reg;
        end
    end

    assign payload_length = payload_length_reg;

endmodule

// ===== hdl/bfp_parse.sv =====
// ----------------------------------------------------------------------------
// bfp_parse
// Input register and frame state machine: one byte per cycle while out_free is high, running
// Fletcher sums, one result per byte.
// ----------------------------------------------------------------------------
module bfp_parse (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic [7:0]       payload_length,
    input  logic             out_free,
    output logic             res_load,
    output bfp_pkg::result_t res
);
    import bfp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    phase_t     phase_reg,     phase_next;
    logic       second_reg,    second_next;
    logic [7:0] len_low_reg,   len_low_next;
    logic [7:0] count_reg,     count_next;
    logic [7:0] sum_a_reg,     sum_a_next;
    logic [7:0] sum_b_reg,     sum_b_next;

    logic [7:0] sum_a_add;
    logic [7:0] sum_b_add;
    logic       hunt;

    assign res_load = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || res_load;

    // input register: refill as the held request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC;
            second_reg  <= 1'b0;
            len_low_reg <= '0;
            count_reg   <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
        end else if (res_load) begin
            phase_reg   <= phase_next;
            second_reg  <= second_next;
            len_low_reg <= len_low_next;
            count_reg   <= count_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        second_next  = second_reg;
        len_low_next = len_low_reg;
        count_next   = count_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        hunt         = 1'b0;

        res.data_valid   = 1'b0;
        res.data_byte    = '0;
        res.data_index   = '0;
        res.frame_status = ST_BUSY;

        sum_a_add = sum_a_reg + in_byte_reg;
        sum_b_add = sum_b_reg + sum_a_add;

        case (phase_reg)
            PH_SYNC: begin
                sum_a_next = '0;
                sum_b_next = '0;
                if (!second_reg && in_byte_reg == SYNC_BYTE0) begin
                    second_next = 1'b1;
                end else if (second_reg && in_byte_reg == SYNC_BYTE1) begin
                    second_next = 1'b0;
                    phase_next  = PH_ID;
                end else begin
                    hunt             = 1'b1;
                    res.frame_status = ST_BAD_SYNC;
                end
            end
            PH_ID: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                if (!second_reg && in_byte_reg == ID_BYTE0) begin
                    second_next = 1'b1;
                end else if (second_reg && in_byte_reg == ID_BYTE1) begin
                    second_next = 1'b0;
                    phase_next  = PH_LEN;
                end else begin
                    hunt             = 1'b1;
                    res.frame_status = ST_BAD_ID;
                end
            end
            PH_LEN: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                if (!second_reg) begin
                    len_low_next = in_byte_reg;
                    second_next  = 1'b1;
                end else begin
                    second_next = 1'b0;
                    if (in_byte_reg == 8'd0 && len_low_reg == payload_length) begin
                        count_next = '0;
                        phase_next = (payload_length == 8'd0) ? PH_SUM : PH_DATA;
                    end else begin
                        hunt             = 1'b1;
                        res.frame_status = ST_BAD_LEN;
                    end
                end
            end
            PH_DATA: begin
                sum_a_next     = sum_a_add;
                sum_b_next     = sum_b_add;
                res.data_valid = 1'b1;
                res.data_byte  = in_byte_reg;
                res.data_index = count_reg;
                // saturating end test: survives a length shrink mid-payload
                if ({1'b0, count_reg} + 9'd1 >= {1'b0, payload_length}) begin
                    count_next  = '0;
                    second_next = 1'b0;
                    phase_next  = PH_SUM;
                end else begin
                    count_next = count_reg + 8'd1;
                end
            end
            PH_SUM: begin
                if (!second_reg) begin
                    if (in_byte_reg == sum_a_reg) begin
                        second_next = 1'b1;
                    end else begin
                        hunt             = 1'b1;
                        res.frame_status = ST_BAD_SUM;
                    end
                end else begin
                    hunt             = 1'b1;
                    res.frame_status = (in_byte_reg == sum_b_reg) ? ST_OK : ST_BAD_SUM;
                end
            end
            default: begin
                hunt = 1'b1;
            end
        endcase

        if (hunt) begin
            phase_next   = PH_SYNC;
            second_next  = 1'b0;
            len_low_next = '0;
            count_next   = '0;
            sum_a_next   = '0;
            sum_b_next   = '0;
        end
    end

    // any finished or failed frame drops back to hunting
    a_status_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res.frame_status != ST_BUSY |=> phase_reg == PH_SYNC)
        else $error("parser did not return to sync hunting after a frame end");

    a_hunt_clears_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && phase_reg == PH_SYNC |=> sum_a_reg == 8'd0 && sum_b_reg == 8'd0)
        else $error("checksum sums not cleared while hunting");

    a_data_only_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res.data_valid |-> phase_reg == PH_DATA && res.frame_status == ST_BUSY)
        else $error("payload byte reported outside the payload phase");

endmodule

// ===== hdl/bfp_out.sv =====
// ----------------------------------------------------------------------------
// bfp_out
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module bfp_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_load,
    input  bfp_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_data_valid,
    output logic [7:0]       m_data_byte,
    output logic [7:0]       m_data_index,
    output logic [2:0]       m_frame_status
);
    import bfp_pkg::*;

    logic    m_valid_reg;
    result_t res_reg;

    // slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_valid   = res_reg.data_valid;
    assign m_data_byte    = res_reg.data_byte;
    assign m_data_index   = res_reg.data_index;
    assign m_frame_status = res_reg.frame_status;

endmodule

// ===== hdl/binary_frame_parser_fletcher.sv =====
// ----------------------------------------------------------------------------
// binary_frame_parser_fletcher
// Byte-stream frame parser: sync 0x23 0x3E, ID 0x06 0x25, 16-bit length,
// payload and two Fletcher-8 check bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carries one received byte per request. Every
//   accepted byte yields exactly one result request on m_valid/m_ready:
//   m_data_valid/m_data_byte/m_data_index flag payload bytes and their index,
//   m_frame_status reports 0 in progress, 1 frame ok, 2 bad sync, 3 bad id,
//   4 bad length, 5 bad checksum.
//   The APB port holds payload_length at address 0 (reset 8); write it only
//   while no byte is in flight.
// Timing:
//   A byte sits in the input register, the state machine and sums update
//   from it, and the result lands in the output register, which drives
//   m_valid. One byte per cycle is sustained while m_ready stays high; the
//   state update of a single byte bounds that figure.
// Reset and stall:
//   aresetn (synchronous, active low) empties both registers and returns the
//   parser to sync hunting. While m_ready is low the result holds, one more
//   byte waits in the input register, and then s_ready drops.
// ----------------------------------------------------------------------------
module binary_frame_parser_fletcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_data_valid,
    output logic [7:0]                       m_data_byte,
    output logic [7:0]                       m_data_index,
    output logic [2:0]                       m_frame_status,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bfp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bfp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import bfp_pkg::*;

    logic [7:0] payload_length;
    logic       out_free;
    logic       res_load;
    result_t    res;

    bfp_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .payload_length (payload_length)
    );

    bfp_parse u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .payload_length (payload_length),
        .out_free       (out_free),
        .res_load       (res_load),
        .res            (res)
    );

    bfp_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res_load       (res_load),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_valid   (m_data_valid),
        .m_data_byte    (m_data_byte),
        .m_data_index   (m_data_index),
        .m_frame_status (m_frame_status)
    );

endmodule
